// ----- design/loa_pkg.sv -----
// loa_pkg: shared constants, types and the ozone extinction profile
// used by the layer ozone absorption top level and its divider
// no dependencies
package loa_pkg;

    localparam int unsigned HEIGHT_W   = 16;
    localparam int unsigned DEPTH_W    = 24;
    localparam int unsigned COEFF_W    = 32;
    localparam int unsigned EXT_W      = 20;
    localparam int unsigned SUM_W      = 36;
    localparam int unsigned PROD_W     = 60;
    localparam int unsigned DEN_W      = 26;
    localparam int unsigned SLAB_IDX_W = 6;
    localparam int unsigned TABLE_MAX  = 64;

    localparam int unsigned SLAB_M     = 2000;
    localparam int unsigned CEILING_M  = 52000;
    localparam int unsigned DEN_SCALE  = 1000;

    // (x * 131) >> 14 for x < 4096 is floor(x / 125) or one below it
    localparam int unsigned RECIP_125   = 131;
    localparam int unsigned RECIP_SHIFT = 14;

    // divider dividend is the product shifted down by the 256 of the denominator
    localparam int unsigned DIVD_W = PROD_W - 8;

    typedef struct packed {
        logic done;
        logic sat;
    } t_div_stat;

    // Q0.24 extinction per slab, entry 0 and everything past the profile read zero
    function automatic logic [EXT_W-1:0] ext_lookup(input logic [SLAB_IDX_W-1:0] idx);
        logic [EXT_W-1:0] v;
        case (idx)
            6'd1:    v = 20'd175322;
            6'd2:    v = 20'd144318;
            6'd3:    v = 20'd111132;
            6'd4:    v = 20'd106300;
            6'd5:    v = 20'd112256;
            6'd6:    v = 20'd172302;
            6'd7:    v = 20'd305681;
            6'd8:    v = 20'd469930;
            6'd9:    v = 20'd507175;
            6'd10:   v = 20'd600457;
            6'd11:   v = 20'd805474;
            6'd12:   v = 20'd969723;
            6'd13:   v = 20'd950933;
            6'd14:   v = 20'd801783;
            6'd15:   v = 20'd604148;
            6'd16:   v = 20'd443757;
            6'd17:   v = 20'd335712;
            6'd18:   v = 20'd237901;
            6'd19:   v = 20'd178006;
            6'd20:   v = 20'd124554;
            6'd21:   v = 20'd91738;
            6'd22:   v = 20'd58536;
            6'd23:   v = 20'd36625;
            6'd24:   v = 20'd21978;
            6'd25:   v = 20'd13724;
            6'd26:   v = 20'd9144;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/loa_in_if.sv -----
// loa_in_if: input channel of the layer ozone absorption block
// depends on loa_pkg for field widths
interface loa_in_if
    import loa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [HEIGHT_W-1:0] layer_bottom;
    logic [HEIGHT_W-1:0] layer_top;
    logic [DEPTH_W-1:0]  column_depth;

    modport source (output valid, output layer_bottom, output layer_top,
                    output column_depth, input ready);
    modport sink   (input valid, input layer_bottom, input layer_top,
                    input column_depth, output ready);
endinterface

// ----- design/loa_out_if.sv -----
// loa_out_if: result channel of the layer ozone absorption block
// depends on loa_pkg for field widths
interface loa_out_if
    import loa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COEFF_W-1:0] absorption_coeff;
    logic               no_path;

    modport source (output valid, output absorption_coeff, output no_path,
                    input ready);
    modport sink   (input valid, input absorption_coeff, input no_path,
                    output ready);
endinterface

// ----- design/loa_div.sv -----
// loa_div: restoring divider, one quotient bit per cycle, flagging quotients past 32 bits
// depends on loa_pkg
module loa_div
    import loa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIVD_W-1:0]  i_dividend,
    input  logic [DEN_W-1:0]   i_divisor,
    output t_div_stat          o_stat,
    output logic [COEFF_W-1:0] o_quot
);

    localparam int unsigned HI_W  = DIVD_W - COEFF_W;
    localparam int unsigned CNT_W = $clog2(COEFF_W + 1);

    logic               r_busy;
    logic               r_done;
    logic               r_sat;
    logic [CNT_W-1:0]   r_cnt;
    logic [DEN_W-1:0]   r_rem;
    logic [DEN_W-1:0]   r_den;
    logic [COEFF_W-1:0] r_q;

    logic [DEN_W:0]     w_trial;
    logic               w_ge;
    logic               w_ovf;

    // quotient overflows 32 bits when the high part already reaches the divisor
    assign w_ovf   = {{(DEN_W-HI_W){1'b0}}, i_dividend[DIVD_W-1:COEFF_W]} >= i_divisor;
    assign w_trial = {r_rem, r_q[COEFF_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (w_ovf) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNT_W'(COEFF_W);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sat <= w_ovf;
            r_den <= i_divisor;
            r_rem <= {{(DEN_W-HI_W){1'b0}}, i_dividend[DIVD_W-1:COEFF_W]};
            r_q   <= i_dividend[COEFF_W-1:0];
        end else if (r_busy) begin
            r_rem <= w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DEN_W-1:0];
            r_q   <= {r_q[COEFF_W-2:0], w_ge};
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.sat  = r_sat;
    assign o_quot      = r_q;

`ifndef NO_ASSERTIONS
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_rem < r_den)
        else $error("divider remainder not below divisor");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held longer than one cycle");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
`endif

endmodule

// ----- design/layer_ozone_absorption.sv -----
// layer_ozone_absorption: ozone optical depth per metre of one atmospheric layer
// depends on loa_pkg, loa_in_if, loa_out_if and loa_div
// sequence: setup, then slab steps in S_WALK, one per cycle through the shared
//   multiplier, ending on the slab that holds the top or with a stop step at the
//   ceiling or table end, then the two product halves (S_MUL0, S_MUL1), the divider
//   start, the divide (quotient bits then done, or done at once on overflow) and the load
// empty or out-of-profile layers skip straight from setup to the result load
// flow: one layer at a time; a result still held by the sink stalls the load and
//   so the input
// reset: synchronous active-low i_rst_n returns the sequencer to idle and empties
//   the result register; no memory to clear
module layer_ozone_absorption
    import loa_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 27
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    loa_in_if.sink      i_in,
    loa_out_if.source   o_out
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_MUL0  = 3'd3;
    localparam logic [2:0] S_MUL1  = 3'd4;
    localparam logic [2:0] S_DIVST = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam int unsigned END_W  = HEIGHT_W + 1;
    localparam int unsigned DZ_W   = $clog2(SLAB_M + 1);
    localparam int unsigned MA_W   = DEPTH_W;
    localparam int unsigned MB_W   = SUM_W / 2;
    localparam int unsigned MP_W   = MA_W + MB_W;
    localparam int unsigned RCP_W  = HEIGHT_W - 4 + 8;
    localparam int unsigned LIM_W  = SLAB_IDX_W + 1;

    // state and working registers
    logic [2:0]            r_state,  n_state;
    logic [HEIGHT_W-1:0]   r_bot;
    logic [HEIGHT_W-1:0]   r_top;
    logic [DEPTH_W-1:0]    r_cd;
    logic [HEIGHT_W-1:0]   r_h;        // height reached so far
    logic [END_W-1:0]      r_end;      // upper edge of the current slab
    logic [SLAB_IDX_W-1:0] r_l;        // current slab index
    logic [SUM_W-1:0]      r_sum;      // sum of thickness times extinction
    logic [PROD_W-1:0]     r_prod;     // sum times column depth
    logic [DEN_W-1:0]      r_den;      // 1000 * thickness
    logic                  r_nopath;

    // result register, decouples the sequencer from the sink
    logic                  r_out_valid;
    logic [COEFF_W-1:0]    r_coeff;
    logic                  r_out_nopath;

    // setup: slab of the bottom height by reciprocal multiply and one correction
    logic [RCP_W-1:0]      w_rcp;
    logic [SLAB_IDX_W-1:0] w_q0;
    logic [END_W-1:0]      w_base0;
    logic [END_W-1:0]      w_rem0;
    logic                  w_corr;
    logic [SLAB_IDX_W-1:0] w_lb;
    logic [END_W-1:0]      w_end0;
    logic                  w_skip;

    // walk step
    logic                  w_stop;
    logic                  w_last;
    logic [HEIGHT_W-1:0]   w_nxt;
    logic [DZ_W-1:0]       w_dz;

    // shared multiplier
    logic [MA_W-1:0]       w_mul_a;
    logic [MB_W-1:0]       w_mul_b;
    logic [MP_W-1:0]       w_mul_p;

    logic                  w_load_out;
    logic                  w_div_start;
    t_div_stat             w_div_stat;
    logic [COEFF_W-1:0]    w_div_quot;

    assign i_in.ready = (r_state == S_IDLE);

    assign w_rcp   = RCP_W'(r_bot[HEIGHT_W-1:4]) * RCP_W'(RECIP_125);
    assign w_q0    = w_rcp[RCP_W-1:RECIP_SHIFT];
    assign w_base0 = END_W'(w_q0) * END_W'(SLAB_M);
    assign w_rem0  = {1'b0, r_bot} - w_base0;
    assign w_corr  = w_rem0 >= END_W'(SLAB_M);
    assign w_lb    = w_corr ? w_q0 + SLAB_IDX_W'(2) : w_q0 + SLAB_IDX_W'(1);
    assign w_end0  = w_corr ? w_base0 + END_W'(2 * SLAB_M) : w_base0 + END_W'(SLAB_M);

    // empty layer, bottom above ceiling, or bottom slab past the profile
    assign w_skip = (r_top <= r_bot)
                 || (r_bot >= HEIGHT_W'(CEILING_M))
                 || ({1'b0, w_lb} >= LIM_W'(TABLE_ENTRIES));

    // the walk ends at the ceiling, at the table end, or once the top is reached
    assign w_stop = (r_h >= HEIGHT_W'(CEILING_M))
                 || ({1'b0, r_l} >= LIM_W'(TABLE_ENTRIES));
    assign w_last = {1'b0, r_top} <= r_end;
    assign w_nxt  = w_last ? r_top : r_end[HEIGHT_W-1:0];
    assign w_dz   = DZ_W'(w_nxt - r_h);

    // one multiplier: slab terms during the walk, then the two halves of sum * depth
    always_comb begin
        w_mul_a = MA_W'(ext_lookup(r_l));
        w_mul_b = MB_W'(w_dz);
        if (r_state == S_MUL0) begin
            w_mul_a = r_cd;
            w_mul_b = r_sum[MB_W-1:0];
        end else if (r_state == S_MUL1) begin
            w_mul_a = r_cd;
            w_mul_b = r_sum[SUM_W-1:MB_W];
        end
    end

    assign w_mul_p = MP_W'(w_mul_a) * MP_W'(w_mul_b);

    assign w_load_out  = (r_state == S_DONE) && (!r_out_valid || o_out.ready);
    assign w_div_start = (r_state == S_DIVST);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in.valid) n_state = S_SETUP;
            S_SETUP: n_state = w_skip ? S_DONE : S_WALK;
            S_WALK:  if (w_stop || w_last) n_state = S_MUL0;
            S_MUL0:  n_state = S_MUL1;
            S_MUL1:  n_state = S_DIVST;
            S_DIVST: n_state = S_DIV;
            S_DIV:   if (w_div_stat.done) n_state = S_DONE;
            S_DONE:  if (w_load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    r_bot <= i_in.layer_bottom;
                    r_top <= i_in.layer_top;
                    r_cd  <= i_in.column_depth;
                end
            end
            S_SETUP: begin
                r_h      <= r_bot;
                r_end    <= w_end0;
                r_l      <= w_lb;
                r_sum    <= '0;
                r_nopath <= w_skip;
                r_den    <= DEN_W'((r_top - r_bot) * DEN_W'(DEN_SCALE));
            end
            S_WALK: begin
                if (!w_stop) begin
                    r_sum <= r_sum + SUM_W'(w_mul_p);
                    r_h   <= w_nxt;
                    if (!w_last) begin
                        r_end <= r_end + END_W'(SLAB_M);
                        r_l   <= r_l + 1'b1;
                    end
                end
            end
            S_MUL0: r_prod <= PROD_W'(w_mul_p);
            S_MUL1: r_prod <= r_prod + {w_mul_p, {MB_W{1'b0}}};
            S_DIVST, S_DIV, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // divider result stays put until the next start, so the beat is built on load
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_nopath <= r_nopath;
            r_coeff      <= r_nopath ? '0 :
                            (w_div_stat.sat ? {COEFF_W{1'b1}} : w_div_quot);
        end
    end

    // floor(sum * depth / (256 * 1000 * t)) = floor((product >> 8) / (1000 * t))
    loa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod[PROD_W-1:8]),
        .i_divisor  (r_den),
        .o_stat     (w_div_stat),
        .o_quot     (w_div_quot)
    );

    assign o_out.valid            = r_out_valid;
    assign o_out.absorption_coeff = r_coeff;
    assign o_out.no_path          = r_out_nopath;

`ifndef NO_ASSERTIONS
    a_nopath_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.no_path |-> o_out.absorption_coeff == '0)
        else $error("no_path beat with nonzero coefficient");

    a_walk_below_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> r_h <= r_top && r_h < r_end[HEIGHT_W-1:0] + 1'b1)
        else $error("walk height left the layer");

    a_dz_one_slab: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK && !w_stop |-> w_dz <= DZ_W'(SLAB_M))
        else $error("slab thickness above one slab");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");
`endif

endmodule
